// ----- sv/stick_radial_deadzone_assert.svh -----
// Assertion helpers for the radial dead-zone block.
`ifndef STICK_RADIAL_DEADZONE_ASSERT_SVH
`define STICK_RADIAL_DEADZONE_ASSERT_SVH
`ifndef SYNTH
`define SRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/srd_pkg.sv -----
`default_nettype none
package srd_pkg;
  localparam int unsigned DzW = 15;
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW = 16;
  localparam int unsigned SumW = 32;
  localparam int unsigned FullScale = 32767;
  localparam int unsigned QW = 16;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned SqrtPerStage = 4;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivPerStage = 4;
  localparam logic [DzW-1:0] LeftDzReset = 15'd7849;
  localparam logic [DzW-1:0] RightDzReset = 15'd8689;
  localparam logic CfgLeft = 1'b0;
  localparam logic CfgRight = 1'b1;

  // Side data that travels along the pipe with each word.
  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic [SampleW-1:0] ax;
    logic [SampleW-1:0] ay;
    logic [DzW-1:0]   dz;
  } srd_side_t;
endpackage
`default_nettype wire

// ----- sv/srd_sqrt.sv -----
`default_nettype none
// Pipelined integer square root, four result bits per stage.
module srd_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     in_vld,
  input  wire logic [srd_pkg::SumW-1:0] in_sum,
  input  wire srd_pkg::srd_side_t       in_side,
  output logic                          out_vld,
  output logic [srd_pkg::MagW-1:0]      out_mag,
  output srd_pkg::srd_side_t            out_side
);
  import srd_pkg::*;
  localparam int unsigned NStg = SqrtSteps / SqrtPerStage;
  localparam int unsigned RemW = MagW + 2;

  logic [NStg:0]           vld_r;
  logic [SumW-1:0]         v_r    [NStg+1];
  logic [RemW-1:0]         rem_r  [NStg+1];
  logic [MagW-1:0]         root_r [NStg+1];
  srd_side_t               side_r [NStg+1];

  always_comb begin
    vld_r[0]  = in_vld;
    v_r[0]    = in_sum;
    rem_r[0]  = '0;
    root_r[0] = '0;
    side_r[0] = in_side;
  end

  for (genvar s = 0; s < NStg; s++) begin : g_stg
    logic [SumW-1:0] v_nxt;
    logic [RemW-1:0] rem_nxt;
    logic [MagW-1:0] root_nxt;
    always_comb begin
      logic [RemW-1:0] trial;
      v_nxt = v_r[s];
      rem_nxt = rem_r[s];
      root_nxt = root_r[s];
      for (int k = 0; k < SqrtPerStage; k++) begin
        rem_nxt = {rem_nxt[RemW-3:0], v_nxt[SumW-1 -: 2]};
        v_nxt = {v_nxt[SumW-3:0], 2'b00};
        trial = {root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          root_nxt = {root_nxt[MagW-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[MagW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (adv) begin
        v_r[s+1] <= v_nxt;
        rem_r[s+1] <= rem_nxt;
        root_r[s+1] <= root_nxt;
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_vld = vld_r[NStg];
  assign out_mag = root_r[NStg];
  assign out_side = side_r[NStg];
endmodule
`default_nettype wire

// ----- sv/srd_div.sv -----
`default_nettype none
// Pipelined restoring divider for a 32-bit dividend with 16-bit quotient,
// four quotient bits per stage. The quotient is known to fit in 16 bits.
module srd_div #(
  parameter type tag_t = logic
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     in_vld,
  input  wire logic [srd_pkg::SumW-1:0] in_num,
  input  wire logic [srd_pkg::QW-1:0]   in_den,
  input  wire tag_t                     in_tag,
  output logic                          out_vld,
  output logic [srd_pkg::QW-1:0]        out_quo,
  output tag_t                          out_tag
);
  import srd_pkg::*;
  localparam int unsigned NStg = DivSteps / DivPerStage;
  localparam int unsigned RemW = QW + 1;

  logic [NStg:0]   vld_r;
  logic [RemW-1:0] rem_r [NStg+1];
  logic [QW-1:0]   lo_r  [NStg+1];
  logic [QW-1:0]   den_r [NStg+1];
  tag_t            tag_r [NStg+1];

  always_comb begin
    vld_r[0] = in_vld;
    rem_r[0] = {1'b0, in_num[SumW-1 -: QW]};
    lo_r[0]  = in_num[QW-1:0];
    den_r[0] = in_den;
    tag_r[0] = in_tag;
  end

  for (genvar s = 0; s < NStg; s++) begin : g_stg
    logic [RemW-1:0] rem_nxt;
    logic [QW-1:0]   lo_nxt;
    always_comb begin
      logic [RemW-1:0] sh;
      rem_nxt = rem_r[s];
      lo_nxt = lo_r[s];
      for (int k = 0; k < DivPerStage; k++) begin
        sh = {rem_nxt[RemW-2:0], lo_nxt[QW-1]};
        if (sh >= {1'b0, den_r[s]}) begin
          rem_nxt = sh - {1'b0, den_r[s]};
          lo_nxt = {lo_nxt[QW-2:0], 1'b1};
        end else begin
          rem_nxt = sh;
          lo_nxt = {lo_nxt[QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (adv) begin
        rem_r[s+1] <= rem_nxt;
        lo_r[s+1] <= lo_nxt;
        den_r[s+1] <= den_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign out_vld = vld_r[NStg];
  assign out_quo = lo_r[NStg];
  assign out_tag = tag_r[NStg];
endmodule
`default_nettype wire

// ----- sv/stick_radial_deadzone.sv -----
`default_nettype none
// Radial dead zone: each accepted input word passes stage 0, the root pipe, stages A
// and B, the rescale divide, stage C, the direction divides and the output register.
// Throughput is one word per cycle unless stalled; the whole pipe advances whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// rst_n is synchronous, active low: it empties the pipe and loads the dead-zone
// registers with 7849 (left) and 8689 (right).
module stick_radial_deadzone #(
  parameter logic [srd_pkg::DzW-1:0] LEFT_DZ_RESET  = srd_pkg::LeftDzReset,
  parameter logic [srd_pkg::DzW-1:0] RIGHT_DZ_RESET = srd_pkg::RightDzReset
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [srd_pkg::DzW-1:0]     cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [srd_pkg::SampleW-1:0] in_stick_x,
  input  wire logic signed [srd_pkg::SampleW-1:0] in_stick_y,
  input  wire logic                        in_is_right,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [srd_pkg::QW-1:0]    out_out_x,
  output logic signed [srd_pkg::QW-1:0]    out_out_y,
  output logic                             out_outside_zone
);
  import srd_pkg::*;
  `include "stick_radial_deadzone_assert.svh"

  typedef struct packed {
    srd_side_t          side;
    logic [MagW-1:0]    mag;
    logic               outside;
  } srd_mid_t;

  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic             outside;
  } srd_fin_t;

  logic [DzW-1:0] left_dz_r, right_dz_r;
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r <= LEFT_DZ_RESET;
      right_dz_r <= RIGHT_DZ_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CfgLeft) left_dz_r <= cfg_data;
      else right_dz_r <= cfg_data;
    end
  end

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 0: absolute values and squares.
  logic           s0_vld_r;
  logic [SumW-1:0] s0_sum_r;
  srd_side_t      s0_side_r;
  logic [SampleW-1:0] ax, ay;
  logic [SumW-1:0] sq_x, sq_y;
  assign ax = in_stick_x[SampleW-1] ? (SampleW)'(-in_stick_x) : in_stick_x;
  assign ay = in_stick_y[SampleW-1] ? (SampleW)'(-in_stick_y) : in_stick_y;
  assign sq_x = ax * ax;
  assign sq_y = ay * ay;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (adv) s0_vld_r <= in_valid;
    if (adv) begin
      s0_sum_r <= sq_x + sq_y;
      s0_side_r <= '{neg_x: in_stick_x[SampleW-1], neg_y: in_stick_y[SampleW-1],
                     ax: ax, ay: ay, dz: in_is_right ? right_dz_r : left_dz_r};
    end
  end

  logic           rt_vld;
  logic [MagW-1:0] rt_mag;
  srd_side_t      rt_side;
  srd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(s0_vld_r), .in_sum(s0_sum_r), .in_side(s0_side_r),
    .out_vld(rt_vld), .out_mag(rt_mag), .out_side(rt_side)
  );

  // Stage A: compare and clamp difference.
  logic       sa_vld_r;
  srd_mid_t   sa_mid_r;
  logic [DzW-1:0] sa_diff_r;
  logic [QW-1:0]  sa_den_r;
  logic [MagW-1:0] clamped;
  assign clamped = (rt_mag > MagW'(FullScale)) ? MagW'(FullScale) : rt_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) sa_vld_r <= 1'b0;
    else if (adv) sa_vld_r <= rt_vld;
    if (adv) begin
      sa_mid_r <= '{side: rt_side, mag: rt_mag, outside: rt_mag > MagW'(rt_side.dz)};
      sa_diff_r <= DzW'(clamped - MagW'(rt_side.dz));
      sa_den_r <= QW'(FullScale) - QW'(rt_side.dz);
    end
  end

  // Stage B: numerator (clamped - dz) * 32767.
  logic       sb_vld_r;
  srd_mid_t   sb_mid_r;
  logic [SumW-1:0] sb_num_r;
  logic [QW-1:0]   sb_den_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sb_vld_r <= 1'b0;
    else if (adv) sb_vld_r <= sa_vld_r;
    if (adv) begin
      sb_mid_r <= sa_mid_r;
      sb_num_r <= (sa_mid_r.outside && sa_den_r != '0) ?
                  SumW'(sa_diff_r) * SumW'(FullScale) : '0;
      sb_den_r <= (sa_den_r != '0) ? sa_den_r : QW'(1);
    end
  end

  logic         d1_vld;
  logic [QW-1:0] d1_scaled;
  srd_mid_t     d1_mid;
  srd_div #(.tag_t(srd_mid_t)) u_div_scale (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(sb_vld_r), .in_num(sb_num_r), .in_den(sb_den_r), .in_tag(sb_mid_r),
    .out_vld(d1_vld), .out_quo(d1_scaled), .out_tag(d1_mid)
  );

  function automatic logic d1_mag_nz(input logic [MagW-1:0] m);
    return m != '0;
  endfunction

  // Stage C: component times scaled, both axes.
  logic       sc_vld_r;
  srd_fin_t   sc_fin_r;
  logic [SumW-1:0] sc_px_r, sc_py_r;
  logic [QW-1:0]   sc_mag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sc_vld_r <= 1'b0;
    else if (adv) sc_vld_r <= d1_vld;
    if (adv) begin
      sc_fin_r <= '{neg_x: d1_mid.side.neg_x, neg_y: d1_mid.side.neg_y,
                    outside: d1_mid.outside};
      sc_px_r <= d1_mid.outside ? d1_mid.side.ax * d1_scaled : '0;
      sc_py_r <= d1_mid.outside ? d1_mid.side.ay * d1_scaled : '0;
      sc_mag_r <= (d1_mag_nz(d1_mid.mag)) ? d1_mid.mag : QW'(1);
    end
  end

  logic         dx_vld, dy_vld;
  logic [QW-1:0] qx, qy;
  srd_fin_t     fx_tag, fy_tag;
  srd_div #(.tag_t(srd_fin_t)) u_div_x (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(sc_vld_r), .in_num(sc_px_r), .in_den(sc_mag_r), .in_tag(sc_fin_r),
    .out_vld(dx_vld), .out_quo(qx), .out_tag(fx_tag)
  );
  srd_div #(.tag_t(srd_fin_t)) u_div_y (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(sc_vld_r), .in_num(sc_py_r), .in_den(sc_mag_r), .in_tag(sc_fin_r),
    .out_vld(dy_vld), .out_quo(qy), .out_tag(fy_tag)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= dx_vld;
    if (adv) begin
      out_out_x <= fx_tag.neg_x ? -qx : qx;
      out_out_y <= fx_tag.neg_y ? -qy : qy;
      out_outside_zone <= fx_tag.outside;
    end
  end

  `SRD_ASSERT_IMPL(a_lanes_agree, clk, rst_n, dx_vld || dy_vld, dx_vld == dy_vld && fx_tag == fy_tag)
  `SRD_ASSERT_IMPL(a_inside_zero, clk, rst_n, out_valid && !out_outside_zone,
                   out_out_x == '0 && out_out_y == '0)
  `SRD_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_out_x) && $stable(out_out_y))
endmodule
`default_nettype wire

// ----- verif/tb_stick_radial_deadzone.sv -----
`timescale 1ns / 1ps

// Scoreboard that holds the expected conditioned stick words in arrival order.
class deadzone_scoreboard;
  typedef struct {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic               outside;
  } cond_word_t;

  cond_word_t pending[$];
  logic [14:0] dz_left;
  logic [14:0] dz_right;
  int errors;

  function new();
    dz_left = srd_pkg::LeftDzReset;
    dz_right = srd_pkg::RightDzReset;
    errors = 0;
  endfunction

  function automatic logic [31:0] int_root(logic [31:0] v);
    logic [31:0] r;
    logic [31:0] b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] steer(logic [15:0] raw, logic [31:0] sc, logic [31:0] mag);
    logic [31:0] a;
    logic [63:0] q;
    a = raw[15] ? (32'h10000 - raw) : raw;
    q = (64'(a) * 64'(sc)) / 64'(mag);
    return raw[15] ? 16'(64'h10000 - q) : q[15:0];
  endfunction

  function void note_sample(logic [15:0] sx, logic [15:0] sy, logic right);
    cond_word_t w;
    logic [31:0] dz;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] mag;
    logic [31:0] cl;
    logic [31:0] sc;
    dz = right ? dz_right : dz_left;
    ax = sx[15] ? (32'h10000 - sx) : sx;
    ay = sy[15] ? (32'h10000 - sy) : sy;
    mag = int_root(ax * ax + ay * ay);
    if (mag <= dz) begin
      w.ox = 0;
      w.oy = 0;
      w.outside = 0;
    end else begin
      cl = (mag > 32767) ? 32767 : mag;
      if (dz >= 32767) sc = 0;
      else sc = 32'((64'(cl - dz) * 64'd32767) / 64'(32767 - dz));
      w.ox = steer(sx, sc, mag);
      w.oy = steer(sy, sc, mag);
      w.outside = 1;
    end
    pending.push_back(w);
  endfunction

  function void check_word(logic signed [15:0] ox, logic signed [15:0] oy, logic outside);
    cond_word_t w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word x=%0d y=%0d o=%0b", $time, ox, oy, outside);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (ox !== w.ox) begin
      $display("%0t: out_x expected %0d actual %0d", $time, w.ox, ox);
      errors++;
    end
    if (oy !== w.oy) begin
      $display("%0t: out_y expected %0d actual %0d", $time, w.oy, oy);
      errors++;
    end
    if (outside !== w.outside) begin
      $display("%0t: outside_zone expected %0b actual %0b", $time, w.outside, outside);
      errors++;
    end
  endfunction
endclass

module tb_stick_radial_deadzone;
  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [14:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_stick_x;
  logic signed [15:0] in_stick_y;
  logic in_is_right;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_out_x;
  logic signed [15:0] out_out_y;
  logic out_outside_zone;

  localparam logic CfgIdxLeft = srd_pkg::CfgLeft;
  localparam logic CfgIdxRight = srd_pkg::CfgRight;
  localparam int Latency = 17;
  localparam int WatchLimit = 20000;

  deadzone_scoreboard sb;
  int send_idle;
  int recv_idle;
  bit recv_hold;
  int quiet;

  stick_radial_deadzone u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_stick_x(in_stick_x),
    .in_stick_y(in_stick_y), .in_is_right(in_is_right), .out_valid(out_valid),
    .out_ready(out_ready), .out_out_x(out_out_x), .out_out_y(out_out_y),
    .out_outside_zone(out_outside_zone)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_out_x, out_out_y, out_outside_zone);
    if (!rst_n) out_ready <= 0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("tb_stick_radial_deadzone: done, errors");
      $finish;
    end
  end

  // The valid line stays up between back-to-back words and drops only while idling.
  task automatic send_sample(logic [15:0] sx, logic [15:0] sy, logic right);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_stick_x <= sx;
    in_stick_y <= sy;
    in_is_right <= right;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(sx, sy, right);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 3) @(posedge clk);
  endtask

  task automatic write_dz(logic idx, logic [14:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CfgIdxLeft) sb.dz_left = v;
    else sb.dz_right = v;
    @(posedge clk);
  endtask

  task automatic random_burst(int n);
    logic [15:0] sx;
    logic [15:0] sy;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 5) begin
        sx = 16'($urandom);
        sy = 16'($urandom);
      end else if (k < 8) begin
        // Square box around the reset dead-zone edges of either stick.
        sx = 16'($signed($urandom_range(20000)) - 10000);
        sy = 16'($signed($urandom_range(20000)) - 10000);
      end else begin
        sx = $urandom_range(1) ? 16'h8000 : 16'h7fff;
        sy = 16'($urandom);
      end
      send_sample(sx, sy, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [15:0] ex[8];
    sb = new();
    ex = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h8001, 16'h1eaa, 16'he156};
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CfgIdxLeft;
    cfg_data = 0;
    in_valid = 0;
    in_stick_x = 0;
    in_stick_y = 0;
    in_is_right = 0;
    out_ready = 0;
    send_idle = 6;
    recv_idle = 71;
    recv_hold = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: corners, axes, zero, and samples at the reset dead zones.
    for (int i = 0; i < 8; i++) send_sample(ex[i], ex[7 - i], i[0]);
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7fff, 16'h7fff, 1'b1);
    send_sample(16'd7849, 16'd0, 1'b0);
    send_sample(16'd7850, 16'd0, 1'b0);
    send_sample(16'd0, 16'd8689, 1'b1);
    send_sample(16'd0, 16'd8690, 1'b1);
    send_sample(16'd0, 16'd0, 1'b1);
    drain();
    write_dz(CfgIdxLeft, 15'd0);
    write_dz(CfgIdxRight, 15'd32766);
    send_sample(16'h0001, 16'd0, 1'b0);
    send_sample(16'h8000, 16'h8000, 1'b1);
    send_sample(16'h7fff, 16'd0, 1'b1);
    send_sample(16'h8000, 16'd0, 1'b1);
    send_sample(16'hffff, 16'hffff, 1'b0);
    random_burst(300);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        recv_hold = 1;
        repeat (60) @(posedge clk);
        recv_hold = 0;
      end
      random_burst(60);
    join
    drain();

    send_idle = 71;
    recv_idle = 6;
    write_dz(CfgIdxLeft, 15'd32766);
    write_dz(CfgIdxRight, 15'd0);
    random_burst(250);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_dz(CfgIdxLeft, 15'($urandom_range(32766)));
    write_dz(CfgIdxRight, 15'($urandom_range(32766)));
    random_burst(250);
    drain();
    write_dz(CfgIdxLeft, 15'h7fff);
    write_dz(CfgIdxRight, 15'h5555);
    random_burst(250);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_stick_radial_deadzone: done, clean");
    else
      $display("tb_stick_radial_deadzone: done, errors");
    $finish;
  end
endmodule
